FILE: hdl/aia_pkg.sv
// Package for the integer ALU: payload structs, opcodes, operation classes.
// No dependencies.
package aia_pkg;

  localparam int unsigned ImplVerReset  = 2;
  localparam int unsigned FeatMaskReset = 263;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned CfgIdxWidth   = 1;
  localparam int unsigned CfgDataWidth  = 9;

  localparam logic [CfgIdxWidth-1:0] CfgImplVer  = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgFeatMask = 1'd1;

  typedef enum logic [5:0] {
    OpAddl = 6'd0, OpS4addl = 6'd1, OpS8addl = 6'd2, OpAddq = 6'd3, OpS4addq = 6'd4,
    OpS8addq = 6'd5, OpCmpeq = 6'd6, OpCmplt = 6'd7, OpCmple = 6'd8, OpCmpult = 6'd9,
    OpCmpule = 6'd10, OpSubl = 6'd11, OpS4subl = 6'd12, OpS8subl = 6'd13,
    OpSubq = 6'd14, OpS4subq = 6'd15, OpS8subq = 6'd16, OpCmpbge = 6'd17,
    OpAnd = 6'd18, OpBic = 6'd19, OpBis = 6'd20, OpOrnot = 6'd21, OpXor = 6'd22,
    OpEqv = 6'd23, OpCmoveq = 6'd24, OpCmovne = 6'd25, OpCmovlt = 6'd26,
    OpCmovge = 6'd27, OpCmovle = 6'd28, OpCmovgt = 6'd29, OpCmovlbs = 6'd30,
    OpCmovlbc = 6'd31, OpImplver = 6'd32, OpAmask = 6'd33, OpMskbl = 6'd34,
    OpMskwl = 6'd35, OpMskll = 6'd36, OpMskql = 6'd37, OpMskwh = 6'd38,
    OpMsklh = 6'd39, OpMskqh = 6'd40, OpExtbl = 6'd41, OpExtwl = 6'd42,
    OpExtll = 6'd43, OpExtql = 6'd44, OpExtwh = 6'd45, OpExtlh = 6'd46,
    OpExtqh = 6'd47, OpInsbl = 6'd48, OpInswl = 6'd49, OpInsll = 6'd50,
    OpInsql = 6'd51, OpInswh = 6'd52, OpInslh = 6'd53, OpInsqh = 6'd54,
    OpZap = 6'd55, OpZapnot = 6'd56, OpSll = 6'd57, OpSrl = 6'd58, OpSra = 6'd59,
    OpMull = 6'd60, OpMulq = 6'd61, OpUmulh = 6'd62, OpNone = 6'd63
  } func_e;

  typedef enum logic [2:0] {
    ClsArith = 3'd0, ClsLogic = 3'd1, ClsCmov = 3'd2, ClsByte = 3'd3,
    ClsShift = 3'd4, ClsMul = 3'd5, ClsMisc = 3'd6, ClsNone = 3'd7
  } cls_e;

  typedef struct packed {
    logic [5:0]  func;
    logic [63:0] ra;
    logic [63:0] rb;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] rc;
    logic        rc_valid;
  } out_beat_t;

  // Decoded item in the queue.
  typedef struct packed {
    cls_e        cls;
    logic [5:0]  func;
    logic [63:0] ra;
    logic [63:0] rb;
  } dec_t;

  // Byte width masks: byte, word, long, quad.
  function automatic logic [7:0] width_mask(input logic [1:0] w);
    logic [7:0] m;
    case (w)
      2'd0: m = 8'h01;
      2'd1: m = 8'h03;
      2'd2: m = 8'h0F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] zapnot8(input logic [63:0] x, input logic [7:0] keep);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[i*8 +: 8] = keep[i] ? x[i*8 +: 8] : 8'h00;
    return r;
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

FILE: hdl/aia_front.sv
// Front end: takes input beats, classifies the opcode, pushes into a small queue.
// Depends on aia_pkg.
module aia_front #(
  parameter int unsigned Depth = aia_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  aia_pkg::in_beat_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output aia_pkg::dec_t     q_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  aia_pkg::dec_t     mem_q [Depth];
  logic [AW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]       cnt_q, cnt_d;
  logic              push;
  aia_pkg::cls_e     cls;

  always_comb begin
    case (aia_pkg::func_e'(in_data_i.func))
      aia_pkg::OpAddl, aia_pkg::OpS4addl, aia_pkg::OpS8addl, aia_pkg::OpAddq,
      aia_pkg::OpS4addq, aia_pkg::OpS8addq, aia_pkg::OpCmpeq, aia_pkg::OpCmplt,
      aia_pkg::OpCmple, aia_pkg::OpCmpult, aia_pkg::OpCmpule, aia_pkg::OpSubl,
      aia_pkg::OpS4subl, aia_pkg::OpS8subl, aia_pkg::OpSubq, aia_pkg::OpS4subq,
      aia_pkg::OpS8subq: cls = aia_pkg::ClsArith;
      aia_pkg::OpCmpbge, aia_pkg::OpAnd, aia_pkg::OpBic, aia_pkg::OpBis,
      aia_pkg::OpOrnot, aia_pkg::OpXor, aia_pkg::OpEqv: cls = aia_pkg::ClsLogic;
      aia_pkg::OpCmoveq, aia_pkg::OpCmovne, aia_pkg::OpCmovlt, aia_pkg::OpCmovge,
      aia_pkg::OpCmovle, aia_pkg::OpCmovgt, aia_pkg::OpCmovlbs,
      aia_pkg::OpCmovlbc: cls = aia_pkg::ClsCmov;
      aia_pkg::OpImplver, aia_pkg::OpAmask: cls = aia_pkg::ClsMisc;
      aia_pkg::OpSll, aia_pkg::OpSrl, aia_pkg::OpSra: cls = aia_pkg::ClsShift;
      aia_pkg::OpMull, aia_pkg::OpMulq, aia_pkg::OpUmulh: cls = aia_pkg::ClsMul;
      aia_pkg::OpNone: cls = aia_pkg::ClsNone;
      default: cls = aia_pkg::ClsByte;
    endcase
  end

  assign in_stall  = (cnt_q == (AW+1)'(Depth));
  assign push      = in_valid && !in_stall;
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = q_pop_i ? ((rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(push) - (AW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{cls: cls, func: in_data_i.func,
                              ra: in_data_i.ra, rb: in_data_i.rb};
  end
endmodule

FILE: hdl/aia_back.sv
// Back end: two-stage execute (operate/partial products, then combine) with output regs.
// Depends on aia_pkg.
module aia_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         impl_ver_i,
  input  logic [8:0]         feat_mask_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  aia_pkg::dec_t      q_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output aia_pkg::out_beat_t out_data_o
);
  // Stage 1 regs
  logic         s1_v_q;
  logic         s1_mul_q;
  logic [5:0]   s1_func_q;
  logic [63:0]  s1_rc_q;
  logic         s1_ok_q;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  // Stage 2 regs
  logic         s2_v_q;
  aia_pkg::out_beat_t s2_q;

  logic adv2, adv1;
  assign adv2    = !s2_v_q || !out_stall;
  assign adv1    = !s1_v_q || adv2;
  assign q_pop_o = q_valid_i && adv1;
  assign out_valid  = s2_v_q;
  assign out_data_o = s2_q;

  logic [63:0] a, b, rc, sa, sum, dif;
  logic [2:0]  off;
  logic [5:0]  sh, f;
  logic        ok, cond, lt;
  logic [7:0]  bm, cmpb;
  logic [15:0] wm;
  aia_pkg::func_e op;

  always_comb begin
    a = q_data_i.ra; b = q_data_i.rb; f = q_data_i.func;
    op = aia_pkg::func_e'(f);
    off = b[2:0]; sh = b[5:0];
    rc = '0; ok = 1'b1; cond = 1'b0; bm = '0; wm = '0;
    case (op)
      aia_pkg::OpS4addl, aia_pkg::OpS4addq, aia_pkg::OpS4subl,
      aia_pkg::OpS4subq: sa = a << 2;
      aia_pkg::OpS8addl, aia_pkg::OpS8addq, aia_pkg::OpS8subl,
      aia_pkg::OpS8subq: sa = a << 3;
      default: sa = a;
    endcase
    sum = sa + b;
    dif = sa - b;
    lt  = $signed(a) < $signed(b);
    for (int i = 0; i < 8; i++) cmpb[i] = a[i*8 +: 8] >= b[i*8 +: 8];
    case (op)
      aia_pkg::OpAddl, aia_pkg::OpS4addl, aia_pkg::OpS8addl: rc = aia_pkg::sext32(sum);
      aia_pkg::OpAddq, aia_pkg::OpS4addq, aia_pkg::OpS8addq: rc = sum;
      aia_pkg::OpSubl, aia_pkg::OpS4subl, aia_pkg::OpS8subl: rc = aia_pkg::sext32(dif);
      aia_pkg::OpSubq, aia_pkg::OpS4subq, aia_pkg::OpS8subq: rc = dif;
      aia_pkg::OpCmpeq:  rc = 64'(a == b);
      aia_pkg::OpCmplt:  rc = 64'(lt);
      aia_pkg::OpCmple:  rc = 64'(lt || a == b);
      aia_pkg::OpCmpult: rc = 64'(a < b);
      aia_pkg::OpCmpule: rc = 64'(a <= b);
      aia_pkg::OpCmpbge: rc = 64'(cmpb);
      aia_pkg::OpAnd:    rc = a & b;
      aia_pkg::OpBic:    rc = a & ~b;
      aia_pkg::OpBis:    rc = a | b;
      aia_pkg::OpOrnot:  rc = a | ~b;
      aia_pkg::OpXor:    rc = a ^ b;
      aia_pkg::OpEqv:    rc = a ^ ~b;
      aia_pkg::OpCmoveq, aia_pkg::OpCmovne, aia_pkg::OpCmovlt, aia_pkg::OpCmovge,
      aia_pkg::OpCmovle, aia_pkg::OpCmovgt, aia_pkg::OpCmovlbs,
      aia_pkg::OpCmovlbc: begin
        case (op)
          aia_pkg::OpCmoveq:  cond = (a == '0);
          aia_pkg::OpCmovne:  cond = (a != '0);
          aia_pkg::OpCmovlt:  cond = a[63];
          aia_pkg::OpCmovge:  cond = !a[63];
          aia_pkg::OpCmovle:  cond = (a == '0) || a[63];
          aia_pkg::OpCmovgt:  cond = (a != '0) && !a[63];
          aia_pkg::OpCmovlbs: cond = a[0];
          default:            cond = !a[0];
        endcase
        rc = cond ? b : '0;
        ok = cond;
      end
      aia_pkg::OpImplver: rc = 64'(impl_ver_i);
      aia_pkg::OpAmask:   rc = b & ~64'(feat_mask_i);
      aia_pkg::OpMskbl, aia_pkg::OpMskwl, aia_pkg::OpMskll, aia_pkg::OpMskql: begin
        wm = 16'(aia_pkg::width_mask(2'(f - 6'd34))) << off;
        rc = aia_pkg::zapnot8(a, ~wm[7:0]);
      end
      aia_pkg::OpMskwh, aia_pkg::OpMsklh, aia_pkg::OpMskqh: begin
        wm = 16'(aia_pkg::width_mask(2'(f - 6'd37))) << off;
        rc = aia_pkg::zapnot8(a, ~wm[15:8]);
      end
      aia_pkg::OpExtbl, aia_pkg::OpExtwl, aia_pkg::OpExtll, aia_pkg::OpExtql:
        rc = aia_pkg::zapnot8(a >> {off, 3'b000}, aia_pkg::width_mask(2'(f - 6'd41)));
      aia_pkg::OpExtwh, aia_pkg::OpExtlh, aia_pkg::OpExtqh:
        rc = aia_pkg::zapnot8(a << (6'(7'd64 - 7'({off, 3'b000}))),
                              aia_pkg::width_mask(2'(f - 6'd44)));
      aia_pkg::OpInsbl, aia_pkg::OpInswl, aia_pkg::OpInsll, aia_pkg::OpInsql: begin
        wm = 16'(aia_pkg::width_mask(2'(f - 6'd48))) << off;
        rc = aia_pkg::zapnot8(a << {off, 3'b000}, wm[7:0]);
      end
      aia_pkg::OpInswh, aia_pkg::OpInslh, aia_pkg::OpInsqh: begin
        wm = 16'(aia_pkg::width_mask(2'(f - 6'd51))) << off;
        rc = (off == '0) ? '0 :
             aia_pkg::zapnot8(a >> (7'd64 - 7'({off, 3'b000})), wm[15:8]);
      end
      aia_pkg::OpZap:    rc = aia_pkg::zapnot8(a, ~b[7:0]);
      aia_pkg::OpZapnot: rc = aia_pkg::zapnot8(a, b[7:0]);
      aia_pkg::OpSll:    rc = a << sh;
      aia_pkg::OpSrl:    rc = a >> sh;
      aia_pkg::OpSra:    rc = 64'($signed(a) >>> sh);
      aia_pkg::OpMull, aia_pkg::OpMulq, aia_pkg::OpUmulh: rc = '0;
      default: begin rc = '0; ok = 1'b0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0;
    end else begin
      if (adv1) s1_v_q <= q_valid_i;
      if (adv2) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_mul_q  <= (q_data_i.cls == aia_pkg::ClsMul);
      s1_func_q <= f;
      s1_rc_q   <= rc;
      s1_ok_q   <= ok;
      ll_q <= 64'(a[31:0])  * 64'(b[31:0]);
      lh_q <= 64'(a[31:0])  * 64'(b[63:32]);
      hl_q <= 64'(a[63:32]) * 64'(b[31:0]);
      hh_q <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  logic [63:0] mid, mres;
  always_comb begin
    mid = 64'(ll_q[63:32]) + 64'(lh_q[31:0]) + 64'(hl_q[31:0]);
    case (aia_pkg::func_e'(s1_func_q))
      aia_pkg::OpMull:  mres = aia_pkg::sext32(ll_q);
      aia_pkg::OpMulq:  mres = {mid[31:0], ll_q[31:0]};
      default: mres = hh_q + 64'(lh_q[63:32]) + 64'(hl_q[63:32]) + 64'(mid[63:32]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_q.rc       <= s1_mul_q ? mres : s1_rc_q;
      s2_q.rc_valid <= s1_ok_q;
    end
  end
endmodule

FILE: hdl/alpha_integer_alu_top.sv
// Top level of the integer ALU: config regs, front end with queue, execute back end.
// Depends on aia_pkg, aia_front, aia_back.
//
//  port group     | dir | handshake              | payload
//  in_*           | in  | in_valid / in_stall    | in_data_i  (func, ra, rb)
//  out_*          | out | out_valid / out_stall  | out_data_o (rc, rc_valid)
//  cfg_*          | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One beat per cycle sustained while out_stall is low; an accepted beat is
// written into the queue, then operate/partial products go into stage 1,
// then combine into the out reg.
// The 4-entry queue lets the front keep taking beats while the output stalls.
// Reset (async, active low) empties queue and pipe and loads the config
// defaults (IMPLVER 2, feature mask 263).
module alpha_integer_alu_top #(
  parameter int unsigned Depth = aia_pkg::QueueDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aia_pkg::in_beat_t                 in_data_i,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aia_pkg::out_beat_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [aia_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [aia_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  logic [1:0] impl_ver_q;
  logic [8:0] feat_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      impl_ver_q  <= 2'(aia_pkg::ImplVerReset);
      feat_mask_q <= 9'(aia_pkg::FeatMaskReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aia_pkg::CfgImplVer:  impl_ver_q  <= cfg_data_i[1:0];
        aia_pkg::CfgFeatMask: feat_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          q_valid, q_pop;
  aia_pkg::dec_t q_data;

  aia_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  aia_back u_back (
    .clk_i, .rst_ni, .impl_ver_i(impl_ver_q), .feat_mask_i(feat_mask_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid, .out_stall, .out_data_o
  );
endmodule

FILE: hdl/aia_checker.sv
// Port-level checks for the integer ALU, bound to the top level.
// Depends on aia_pkg.
module aia_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid,
  input logic               in_stall,
  input aia_pkg::in_beat_t  in_data_i,
  input logic               out_valid,
  input logic               out_stall,
  input aia_pkg::out_beat_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_stall |=> in_valid && $stable(in_data_i))
    else $error("input beat dropped or changed under stall");

  a_no_result_on_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("output valid right after reset");

  a_skipped_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data_o.rc_valid |-> out_data_o.rc == 64'd0)
    else $error("unwritten result carries nonzero value");

  a_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid && $past(!out_valid) && $past(!in_valid) |-> !in_stall)
    else $error("input stalled while pipe is idle");
endmodule

bind alpha_integer_alu_top aia_checker u_aia_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
  .out_valid, .out_stall, .out_data_o
);
